@@ rtl/pse_pkg.sv @@
// Shared types, constants and the CRC-32 byte step of the PNG stored-stream encoder.
package pse_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned TOTAL_W = 28;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  typedef struct packed {
    logic [7:0] pix;
    logic       first;
    logic       row_start;
    logic       last;
  } token_t;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } img_size_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/pse_queue.sv @@
// Small register queue of classified transactions between front and back.
module pse_queue
  import pse_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  token_t wdata,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output token_t rdata
);

  token_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r;
  logic [QPTR_W-1:0]   rp_r;
  logic [QPTR_W:0]     cnt_r;
  logic                do_push;
  logic                do_pop;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

endmodule

@@ rtl/pse_front.sv @@
// Front end: configuration registers, input acceptance and row/image classification.
module pse_front
  import pse_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  input  logic        in_push,
  input  logic [7:0]  in_pixel_byte,
  input  logic        q_full,
  output logic        q_push,
  output token_t      q_wdata,
  output img_size_t   size
);

  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic [14:0]       row_bytes_r;
  logic [SIZE_W-1:0] rows_r;
  logic              started_r;
  logic              wr;
  logic [SIZE_W-1:0] wval;
  logic [SIZE_W-1:0] w_clamped;
  logic [SIZE_W-1:0] h_clamped;
  logic              row_end;
  logic              img_end;

  assign wr   = cfg_psel && cfg_penable && cfg_pwrite && !started_r;
  assign wval = cfg_pwdata[SIZE_W-1:0];

  always_comb begin
    w_clamped = wval;
    if (wval == '0) begin
      w_clamped = SIZE_W'(1);
    end else if ({2'b00, wval} > 15'(MAX_WIDTH)) begin
      w_clamped = SIZE_W'(MAX_WIDTH);
    end
    h_clamped = wval;
    if (wval == '0) begin
      h_clamped = SIZE_W'(1);
    end else if ({2'b00, wval} > 15'(MAX_HEIGHT)) begin
      h_clamped = SIZE_W'(MAX_HEIGHT);
    end
  end

  assign cfg_prdata = {19'd0, cfg_paddr[2] ? height_r : width_r};
  assign size       = '{width: width_r, height: height_r};

  assign q_push  = in_push && !q_full;
  assign row_end = (row_bytes_r + 15'd1) == {width_r, 2'b00};
  assign img_end = row_end && ((rows_r + 1'b1) == height_r);

  assign q_wdata = '{pix: in_pixel_byte, first: !started_r,
                     row_start: (row_bytes_r == '0), last: img_end};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= SIZE_W'(1);
      height_r    <= SIZE_W'(1);
      row_bytes_r <= '0;
      rows_r      <= '0;
      started_r   <= 1'b0;
    end else begin
      if (wr && !cfg_paddr[2]) begin
        width_r <= w_clamped;
      end
      if (wr && cfg_paddr[2]) begin
        height_r <= h_clamped;
      end
      if (q_push) begin
        if (img_end) begin
          row_bytes_r <= '0;
          rows_r      <= '0;
          started_r   <= 1'b0;
        end else if (row_end) begin
          row_bytes_r <= '0;
          rows_r      <= rows_r + 1'b1;
          started_r   <= 1'b1;
        end else begin
          row_bytes_r <= row_bytes_r + 15'd1;
          started_r   <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/pse_back.sv @@
// Back end: byte sequencer for PNG headers, stored blocks, checksums and trailer.
module pse_back
  import pse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  img_size_t  size,
  input  logic       q_empty,
  input  token_t     q_rdata,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_out_byte,
  output logic       out_last_of_run,
  output logic       out_image_done
);

  typedef enum logic [2:0] {ST_IDLE, ST_HDR, ST_BLK, ST_RAW, ST_TRL} state_t;

  state_t             state_r, state_nxt;
  logic [5:0]         idx_r, idx_nxt;
  token_t             tok_r, tok_nxt;
  logic               fpend_r, fpend_nxt;
  logic [7:0]         raw_r, raw_nxt;
  logic [31:0]        crc_r, crc_nxt;
  logic [31:0]        hold_r, hold_nxt;
  logic [15:0]        alow_r, alow_nxt;
  logic [15:0]        ahigh_r, ahigh_nxt;
  logic [TOTAL_W-1:0] pos_r, pos_nxt;
  logic [15:0]        bleft_r, bleft_nxt;
  logic               ov_r, ov_nxt;
  logic [7:0]         ob_r;
  logic               olast_r;
  logic               odone_r;

  logic [TOTAL_W-1:0] total_r;
  logic [12:0]        blocks_r;
  logic [31:0]        idat_len_r;
  logic [TOTAL_W:0]   bsum;
  logic [16:0]        bpart;

  logic               adv;
  logic               finish;
  logic               load;
  logic [7:0]         byte_c;
  logic               crc_rst;
  logic               crc_first;
  logic               crc_cont;
  logic [31:0]        crc_fin;
  logic [1:0]         crc_ofs;
  logic [TOTAL_W-1:0] rest;
  logic [15:0]        blen;
  logic               bfinal;
  logic [16:0]        lsum;
  logic [15:0]        lnew;
  logic [16:0]        hsum;
  logic [15:0]        hnew;

  assign bsum  = {1'b0, total_r} + (TOTAL_W+1)'(65534);
  assign bpart = 17'(bsum[TOTAL_W:16]) + {1'b0, bsum[15:0]};

  always_ff @(posedge clk) begin
    total_r    <= ({13'd0, size.width, 2'b00} + 28'd1) * {15'd0, size.height};
    blocks_r   <= 13'(bsum[TOTAL_W:16]) + 13'(bpart >= 17'd65535);
    idat_len_r <= 32'(total_r) + 32'd6 + {17'd0, blocks_r, 2'b00} + {19'd0, blocks_r};
  end

  assign crc_fin = ~crc_r;
  assign rest    = total_r - pos_r;
  assign bfinal  = (rest <= TOTAL_W'(65535));
  assign blen    = bfinal ? rest[15:0] : 16'hFFFF;
  assign lsum    = {1'b0, alow_r} + {9'd0, raw_r};
  assign lnew    = (lsum >= ADLER_MOD) ? 16'(lsum - ADLER_MOD) : lsum[15:0];
  assign hsum    = {1'b0, ahigh_r} + {1'b0, lnew};
  assign hnew    = (hsum >= ADLER_MOD) ? 16'(hsum - ADLER_MOD) : hsum[15:0];

  assign adv = (state_r != ST_IDLE) && (!ov_r || out_pop);

  always_comb begin
    byte_c    = 8'h00;
    crc_rst   = 1'b0;
    crc_first = 1'b0;
    crc_cont  = 1'b0;
    crc_ofs   = 2'd0;
    unique case (state_r)
      ST_HDR: begin
        case (idx_r)
          6'd0:  byte_c = 8'h89;
          6'd1:  byte_c = 8'h50;
          6'd2:  byte_c = 8'h4E;
          6'd3:  byte_c = 8'h47;
          6'd4:  byte_c = 8'h0D;
          6'd5:  byte_c = 8'h0A;
          6'd6:  byte_c = 8'h1A;
          6'd7:  byte_c = 8'h0A;
          6'd11: byte_c = 8'h0D;
          6'd12: begin
            byte_c  = 8'h49;
            crc_rst = 1'b1;
          end
          6'd13: byte_c = 8'h48;
          6'd14: byte_c = 8'h44;
          6'd15: byte_c = 8'h52;
          6'd18: byte_c = {3'd0, size.width[12:8]};
          6'd19: byte_c = size.width[7:0];
          6'd22: byte_c = {3'd0, size.height[12:8]};
          6'd23: byte_c = size.height[7:0];
          6'd24: byte_c = 8'h08;
          6'd25: byte_c = 8'h06;
          6'd29: crc_first = 1'b1;
          6'd30, 6'd31, 6'd32: begin
            crc_cont = 1'b1;
            crc_ofs  = 2'(idx_r - 6'd29);
          end
          6'd33: byte_c = idat_len_r[31:24];
          6'd34: byte_c = idat_len_r[23:16];
          6'd35: byte_c = idat_len_r[15:8];
          6'd36: byte_c = idat_len_r[7:0];
          6'd37: begin
            byte_c  = 8'h49;
            crc_rst = 1'b1;
          end
          6'd38: byte_c = 8'h44;
          6'd39: byte_c = 8'h41;
          6'd40: byte_c = 8'h54;
          6'd41: byte_c = 8'h78;
          6'd42: byte_c = 8'h01;
          default: byte_c = 8'h00;
        endcase
      end
      ST_BLK: begin
        case (idx_r[2:0])
          3'd0:    byte_c = {7'd0, bfinal};
          3'd1:    byte_c = blen[7:0];
          3'd2:    byte_c = blen[15:8];
          3'd3:    byte_c = ~blen[7:0];
          default: byte_c = ~blen[15:8];
        endcase
      end
      ST_RAW: byte_c = raw_r;
      ST_TRL: begin
        case (idx_r)
          6'd0:  byte_c = ahigh_r[15:8];
          6'd1:  byte_c = ahigh_r[7:0];
          6'd2:  byte_c = alow_r[15:8];
          6'd3:  byte_c = alow_r[7:0];
          6'd4, 6'd16: crc_first = 1'b1;
          6'd5, 6'd6, 6'd7: begin
            crc_cont = 1'b1;
            crc_ofs  = 2'(idx_r - 6'd4);
          end
          6'd12: begin
            byte_c  = 8'h49;
            crc_rst = 1'b1;
          end
          6'd13: byte_c = 8'h45;
          6'd14: byte_c = 8'h4E;
          6'd15: byte_c = 8'h44;
          6'd17, 6'd18, 6'd19: begin
            crc_cont = 1'b1;
            crc_ofs  = 2'(idx_r - 6'd16);
          end
          default: byte_c = 8'h00;
        endcase
      end
      default: byte_c = 8'h00;
    endcase
    if (crc_first) begin
      byte_c = crc_fin[31:24];
    end else if (crc_cont) begin
      case (crc_ofs)
        2'd1:    byte_c = hold_r[23:16];
        2'd2:    byte_c = hold_r[15:8];
        default: byte_c = hold_r[7:0];
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    tok_nxt   = tok_r;
    fpend_nxt = fpend_r;
    raw_nxt   = raw_r;
    crc_nxt   = crc_r;
    hold_nxt  = hold_r;
    alow_nxt  = alow_r;
    ahigh_nxt = ahigh_r;
    pos_nxt   = pos_r;
    bleft_nxt = bleft_r;
    finish    = 1'b0;
    ov_nxt    = ov_r && !out_pop;

    if (adv) begin
      ov_nxt  = 1'b1;
      crc_nxt = crc_byte(crc_rst ? CRC_INIT : crc_r, byte_c);
      if (crc_first) begin
        hold_nxt = crc_fin;
      end
      idx_nxt = idx_r + 6'd1;
      unique case (state_r)
        ST_HDR: begin
          if (idx_r == 6'd42) begin
            idx_nxt   = '0;
            raw_nxt   = tok_r.row_start ? 8'h00 : tok_r.pix;
            fpend_nxt = tok_r.row_start;
            state_nxt = (bleft_r == '0) ? ST_BLK : ST_RAW;
          end
        end
        ST_BLK: begin
          if (idx_r == 6'd4) begin
            idx_nxt   = '0;
            bleft_nxt = blen;
            state_nxt = ST_RAW;
          end
        end
        ST_RAW: begin
          idx_nxt   = '0;
          bleft_nxt = bleft_r - 16'd1;
          pos_nxt   = pos_r + TOTAL_W'(1);
          alow_nxt  = lnew;
          ahigh_nxt = hnew;
          if (fpend_r) begin
            fpend_nxt = 1'b0;
            raw_nxt   = tok_r.pix;
            state_nxt = (bleft_nxt == '0) ? ST_BLK : ST_RAW;
          end else if (tok_r.last) begin
            state_nxt = ST_TRL;
          end else begin
            finish = 1'b1;
          end
        end
        ST_TRL: begin
          if (idx_r == 6'd19) begin
            finish    = 1'b1;
            crc_nxt   = CRC_INIT;
            alow_nxt  = 16'd1;
            ahigh_nxt = '0;
            pos_nxt   = '0;
            bleft_nxt = '0;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end

    if (finish) begin
      state_nxt = ST_IDLE;
    end
    load = ((state_r == ST_IDLE) || finish) && !q_empty;
    if (load) begin
      tok_nxt = q_rdata;
      idx_nxt = '0;
      if (q_rdata.first) begin
        state_nxt = ST_HDR;
      end else begin
        raw_nxt   = q_rdata.row_start ? 8'h00 : q_rdata.pix;
        fpend_nxt = q_rdata.row_start;
        state_nxt = (bleft_nxt == '0) ? ST_BLK : ST_RAW;
      end
    end
  end

  assign q_pop           = load;
  assign out_empty       = !ov_r;
  assign out_out_byte    = ob_r;
  assign out_last_of_run = olast_r;
  assign out_image_done  = odone_r;

  always_ff @(posedge clk) begin
    tok_r  <= tok_nxt;
    raw_r  <= raw_nxt;
    hold_r <= hold_nxt;
    if (adv) begin
      ob_r    <= byte_c;
      olast_r <= finish;
      odone_r <= finish && (state_r == ST_TRL);
    end
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      fpend_r <= 1'b0;
      crc_r   <= CRC_INIT;
      alow_r  <= 16'd1;
      ahigh_r <= '0;
      pos_r   <= '0;
      bleft_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      fpend_r <= fpend_nxt;
      crc_r   <= crc_nxt;
      alow_r  <= alow_nxt;
      ahigh_r <= ahigh_nxt;
      pos_r   <= pos_nxt;
      bleft_r <= bleft_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

@@ rtl/png_stored_stream_encoder_core.sv @@
// Top level of the PNG stored-stream encoder: front end, transaction queue and byte sequencer.
//
//   Channel  Ports                                  Direction  Transaction
//   input    in_push, in_full, in_pixel_byte        in         one RGBA byte
//   result   out_empty, out_pop, out_out_byte, ...  out        one PNG stream byte
//   config   cfg_psel ... cfg_pready                in         register write or read
//
// The back end emits one stream byte per cycle while the output is not stalled, and header,
// block header and trailer bytes come on top of the pixel bytes; a four-entry queue absorbs them.
// A stream holds 43 header and 20 trailer bytes, 5 per block, one per row and one per pixel byte.
// Reset is synchronous and active low and sets width and height to 1.
// A stalled output holds the back end; a full queue deasserts acceptance at the input.
module png_stored_stream_encoder_core
  import pse_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_pixel_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_out_byte,
  output logic        out_last_of_run,
  output logic        out_image_done
);

  token_t    q_wdata;
  token_t    q_rdata;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  img_size_t size;

  assign cfg_pready = 1'b1;
  assign in_full    = q_full;

  pse_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .in_push      (in_push),
    .in_pixel_byte(in_pixel_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata),
    .size         (size)
  );

  pse_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .empty(q_empty),
    .rdata(q_rdata)
  );

  pse_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .size           (size),
    .q_empty        (q_empty),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_out_byte   (out_out_byte),
    .out_last_of_run(out_last_of_run),
    .out_image_done (out_image_done)
  );

endmodule
